// ===== sv/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the tile slot cache
// Operation and statistic codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned DEF_NUM_SLOTS  = 256;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_TIME_BITS  = 48;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned TKEY_W  = 32;
  localparam int unsigned NOW_W   = 48;
  localparam int unsigned MAXF_W  = 9;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned SSEL_W  = 3;
  localparam int unsigned STAT_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_PEEK    = 3'd2,
    OP_EVICT   = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_READKEY = 3'd5,
    OP_STAT    = 3'd6
  } op_e;

  typedef enum logic [SSEL_W-1:0] {
    STAT_RESIDENT = 3'd0,
    STAT_FREE     = 3'd1,
    STAT_HITS     = 3'd2,
    STAT_MISSES   = 3'd3,
    STAT_EVICTS   = 3'd4,
    STAT_INSERTS  = 3'd5
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic start_scan;
    logic clear;
    logic upd_hit;
    logic count_hit;
    logic count_miss;
    logic count_insert;
    logic peek_hit;
    logic ins_free;
    logic ins_evict;
    logic evict_one;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_ok;
    logic            max_zero;
    logic            scan_done;
    logic            found;
    logic            has_old;
    logic            depth_nz;
    logic            more;
  } status_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    return (&v) ? v : v + STAT_W'(1);
  endfunction

endpackage

// ===== sv/tsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_req_if / tsc_rsp_if: request and response channels
// Valid/ready handshake with the operation fields and the result fields.
// ----------------------------------------------------------------------------
interface tsc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] tile_key;
  logic        tile_key_ok;
  logic [47:0] now_time;
  logic [8:0]  max_free;
  logic [7:0]  slot_select;
  logic [2:0]  stat_select;

  modport source (output valid, operation, tile_key, tile_key_ok, now_time, max_free,
                  slot_select, stat_select, input ready);
  modport sink (input valid, operation, tile_key, tile_key_ok, now_time, max_free,
                slot_select, stat_select, output ready);
endinterface

interface tsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot_index;
  logic        slot_none;
  logic        was_resident;
  logic        did_evict;
  logic [8:0]  freed_count;
  logic [31:0] key_out;
  logic        key_out_ok;
  logic [47:0] stat_value;

  modport source (output valid, slot_index, slot_none, was_resident, did_evict,
                  freed_count, key_out, key_out_ok, stat_value, input ready);
  modport sink (input valid, slot_index, slot_none, was_resident, did_evict,
                freed_count, key_out, key_out_ok, stat_value, output ready);
endinterface

// ===== sv/tsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_ctrl: operation sequencer
// Dispatches each transaction, runs slot scans and issues update commands.
// ----------------------------------------------------------------------------
module tsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  tsc_pkg::status_t  status_i,
  output tsc_pkg::cmd_t     cmd_o
);
  import tsc_pkg::*;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_FINISH;
        case (status_i.op)
          OP_INSERT: begin
            if (status_i.key_ok) begin
              cmd_o.start_scan = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          OP_LOOKUP, OP_PEEK: begin
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end
          OP_EVICT: begin
            if (!status_i.max_zero) begin
              cmd_o.start_scan = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          OP_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_FINISH;
        case (status_i.op)
          OP_INSERT: begin
            cmd_o.count_insert = 1'b1;
            if (status_i.found) begin
              cmd_o.upd_hit = 1'b1;
            end else if (status_i.depth_nz) begin
              cmd_o.ins_free = 1'b1;
            end else if (status_i.has_old) begin
              cmd_o.ins_evict = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (status_i.found) begin
              cmd_o.upd_hit   = 1'b1;
              cmd_o.count_hit = 1'b1;
            end else begin
              cmd_o.count_miss = 1'b1;
            end
          end
          OP_PEEK: cmd_o.peek_hit = status_i.found;
          OP_EVICT: begin
            if (status_i.has_old) begin
              cmd_o.evict_one = 1'b1;
              if (status_i.more) begin
                cmd_o.start_scan = 1'b1;
                state_d          = ST_SCAN;
              end
            end
          end
          default: ;
        endcase
      end
      ST_FINISH: begin
        // load the output register only once the previous result has left
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.finish = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== sv/tsc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_dp: slot store and scan datapath
// Key and time memories, valid bits, free-slot stack, counters, result register.
// ----------------------------------------------------------------------------
module tsc_dp #(
  parameter int unsigned NUM_SLOTS  = tsc_pkg::DEF_NUM_SLOTS,
  parameter int unsigned KEY_BITS   = tsc_pkg::DEF_KEY_BITS,
  parameter int unsigned TIME_BITS  = tsc_pkg::DEF_TIME_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsc_pkg::cmd_t               cmd_i,
  output tsc_pkg::status_t            status_o,
  input  logic [tsc_pkg::OP_W-1:0]    operation_i,
  input  logic [tsc_pkg::TKEY_W-1:0]  tile_key_i,
  input  logic                        tile_key_ok_i,
  input  logic [tsc_pkg::NOW_W-1:0]   now_time_i,
  input  logic [tsc_pkg::MAXF_W-1:0]  max_free_i,
  input  logic [tsc_pkg::SEL_W-1:0]   slot_select_i,
  input  logic [tsc_pkg::SSEL_W-1:0]  stat_select_i,
  output logic [7:0]                  slot_index_o,
  output logic                        slot_none_o,
  output logic                        was_resident_o,
  output logic                        did_evict_o,
  output logic [8:0]                  freed_count_o,
  output logic [31:0]                 key_out_o,
  output logic                        key_out_ok_o,
  output logic [tsc_pkg::STAT_W-1:0]  stat_value_o
);
  import tsc_pkg::*;

  localparam int unsigned IW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  // request registers
  logic [OP_W-1:0]   op_q;
  logic [KEY_BITS-1:0] key_q;
  logic              key_ok_q;
  logic [TIME_BITS-1:0] now_q;
  logic [MAXF_W-1:0] maxf_q;
  logic [SEL_W-1:0]  sel_q;
  logic [SSEL_W-1:0] ssel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= operation_i;
      key_q    <= KEY_BITS'(tile_key_i);
      key_ok_q <= tile_key_ok_i;
      now_q    <= TIME_BITS'(now_time_i);
      maxf_q   <= max_free_i;
      sel_q    <= slot_select_i;
      ssel_q   <= stat_select_i;
    end
  end

  // memories
  logic [KEY_BITS-1:0]  key_mem  [NUM_SLOTS];
  logic [TIME_BITS-1:0] time_mem [NUM_SLOTS];
  logic [IW-1:0]        stk_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;

  // scan
  logic                 scan_q, pact_q, pval_q;
  logic [IW-1:0]        idx_q, pidx_q, rd_addr;
  logic [KEY_BITS-1:0]  key_rd_q;
  logic [TIME_BITS-1:0] time_rd_q;
  logic                 found_q, old_v_q;
  logic [IW-1:0]        mt_idx_q, old_idx_q;
  logic [TIME_BITS-1:0] old_t_q;

  // stack, counters, results
  logic [CW-1:0]     depth_q, mark_q, resident_q, free_cnt;
  logic [IW-1:0]     top_pos, stk_rd_q, pop_slot;
  logic              sel_in_range;
  logic [STAT_W-1:0] hits_q, misses_q, evicts_q, inserts_q;
  logic [MAXF_W-1:0] freed_q;
  logic [IW-1:0]     res_slot_q;
  logic              res_none_q, res_was_q, res_ev_q;

  logic                 wr_key_en, wr_time_en;
  logic [IW-1:0]        wr_addr;

  assign sel_in_range = (int'(sel_q) < NUM_SLOTS);
  assign rd_addr      = scan_q ? idx_q : IW'(sel_q);
  assign top_pos      = IW'(depth_q - CW'(1));
  assign pop_slot     = (CW'(depth_q - CW'(1)) < mark_q) ?
                        (IW'(NUM_SLOTS - 1) - top_pos) : stk_rd_q;
  assign free_cnt     = CW'(NUM_SLOTS) - resident_q;

  always_comb begin
    wr_key_en  = 1'b0;
    wr_time_en = 1'b0;
    wr_addr    = mt_idx_q;
    if (cmd_i.upd_hit) begin
      wr_time_en = 1'b1;
    end else if (cmd_i.ins_free) begin
      wr_key_en  = 1'b1;
      wr_time_en = 1'b1;
      wr_addr    = pop_slot;
    end else if (cmd_i.ins_evict) begin
      wr_key_en  = 1'b1;
      wr_time_en = 1'b1;
      wr_addr    = old_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= key_q;
    end
    if (wr_time_en) begin
      time_mem[wr_addr] <= now_q;
    end
    key_rd_q  <= key_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
    pval_q    <= valid_q[rd_addr];
    pidx_q    <= rd_addr;
    stk_rd_q  <= stk_mem[top_pos];
    if (cmd_i.evict_one && (depth_q < CW'(NUM_SLOTS))) begin
      stk_mem[IW'(depth_q)] <= old_idx_q;
    end
  end

  // scan counter and trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= 1'b0;
      pact_q  <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
      old_v_q <= 1'b0;
    end else begin
      pact_q <= scan_q;
      if (cmd_i.start_scan) begin
        scan_q  <= 1'b1;
        idx_q   <= '0;
        found_q <= 1'b0;
        old_v_q <= 1'b0;
      end else if (scan_q) begin
        idx_q <= idx_q + IW'(1);
        if (idx_q == IW'(NUM_SLOTS - 1)) begin
          scan_q <= 1'b0;
        end
      end
      if (pact_q && pval_q) begin
        if (key_ok_q && !found_q && (key_rd_q == key_q)) begin
          found_q <= 1'b1;
        end
        if (!old_v_q || (time_rd_q < old_t_q)) begin
          old_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pact_q && pval_q) begin
      if (key_ok_q && !found_q && (key_rd_q == key_q)) begin
        mt_idx_q <= pidx_q;
      end
      // strict compare keeps the lowest index on equal times
      if (!old_v_q || (time_rd_q < old_t_q)) begin
        old_idx_q <= pidx_q;
        old_t_q   <= time_rd_q;
      end
    end
  end

  // valid bits, stack pointer, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      depth_q    <= CW'(NUM_SLOTS);
      mark_q     <= CW'(NUM_SLOTS);
      resident_q <= '0;
      hits_q     <= '0;
      misses_q   <= '0;
      evicts_q   <= '0;
      inserts_q  <= '0;
      freed_q    <= '0;
    end else begin
      if (cmd_i.latch) begin
        freed_q <= '0;
      end
      if (cmd_i.clear) begin
        valid_q    <= '0;
        depth_q    <= CW'(NUM_SLOTS);
        mark_q     <= CW'(NUM_SLOTS);
        resident_q <= '0;
      end
      if (cmd_i.ins_free) begin
        valid_q[pop_slot] <= 1'b1;
        depth_q           <= depth_q - CW'(1);
        resident_q        <= resident_q + CW'(1);
      end
      if (cmd_i.evict_one) begin
        valid_q[old_idx_q] <= 1'b0;
        resident_q         <= resident_q - CW'(1);
        freed_q            <= freed_q + MAXF_W'(1);
        if (depth_q < CW'(NUM_SLOTS)) begin
          depth_q <= depth_q + CW'(1);
          if (depth_q < mark_q) begin
            mark_q <= depth_q;
          end
        end
      end
      if (cmd_i.count_hit)    hits_q    <= sat_inc(hits_q);
      if (cmd_i.count_miss)   misses_q  <= sat_inc(misses_q);
      if (cmd_i.count_insert) inserts_q <= sat_inc(inserts_q);
      if (cmd_i.ins_evict || cmd_i.evict_one) evicts_q <= sat_inc(evicts_q);
    end
  end

  // per-transaction result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      res_slot_q <= '0;
      res_none_q <= 1'b1;
      res_was_q  <= 1'b0;
      res_ev_q   <= 1'b0;
    end
    if (cmd_i.upd_hit) begin
      res_slot_q <= mt_idx_q;
      res_none_q <= 1'b0;
      res_was_q  <= 1'b1;
    end
    if (cmd_i.peek_hit) begin
      res_slot_q <= mt_idx_q;
      res_none_q <= 1'b0;
    end
    if (cmd_i.ins_free) begin
      res_slot_q <= pop_slot;
      res_none_q <= 1'b0;
    end
    if (cmd_i.ins_evict) begin
      res_slot_q <= old_idx_q;
      res_none_q <= 1'b0;
      res_ev_q   <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      slot_index_o   <= 8'(res_slot_q);
      slot_none_o    <= res_none_q;
      was_resident_o <= res_was_q;
      did_evict_o    <= res_ev_q;
      freed_count_o  <= '0;
      key_out_o      <= '0;
      key_out_ok_o   <= 1'b0;
      stat_value_o   <= '0;
      case (op_q)
        OP_EVICT: freed_count_o <= freed_q;
        OP_READKEY: begin
          slot_index_o <= sel_q;
          slot_none_o  <= !sel_in_range;
          if (sel_in_range && pval_q) begin
            key_out_o    <= 32'(key_rd_q);
            key_out_ok_o <= 1'b1;
          end
        end
        OP_STAT: begin
          case (ssel_q)
            STAT_RESIDENT: stat_value_o <= STAT_W'(resident_q);
            STAT_FREE:     stat_value_o <= STAT_W'(free_cnt);
            STAT_HITS:     stat_value_o <= hits_q;
            STAT_MISSES:   stat_value_o <= misses_q;
            STAT_EVICTS:   stat_value_o <= evicts_q;
            STAT_INSERTS:  stat_value_o <= inserts_q;
            default:       stat_value_o <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign status_o.op        = op_q;
  assign status_o.key_ok    = key_ok_q;
  assign status_o.max_zero  = (maxf_q == '0);
  assign status_o.scan_done = !scan_q && !pact_q;
  assign status_o.found     = found_q;
  assign status_o.has_old   = old_v_q;
  assign status_o.depth_nz  = (depth_q != '0);
  assign status_o.more      = (({1'b0, freed_q} + 10'd1) < {1'b0, maxf_q});

endmodule

// ===== sv/tile_slot_cache_lru_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_slot_cache_lru_core: fully associative tile slot cache, LRU by time
// Insert, lookup, peek, evict-oldest, clear, slot key and statistic reads.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | contents
//  req_i   | in  | valid / ready | operation and its operands
//  rsp_o   | out | valid / ready | one result per request
//
//  Insert with a valid key, lookup and peek each run one full key/time
//  memory scan, one slot per cycle through the single read port.
//  Evict runs a further scan for each further slot it frees; clear, slot key
//  and statistic reads run no scan.
//  Reset clears the valid bits and the stack pointer at once; no sweep.
//  A held result does not block the next request until its own result.
// ----------------------------------------------------------------------------
module tile_slot_cache_lru_core #(
  parameter int unsigned NUM_SLOTS  = tsc_pkg::DEF_NUM_SLOTS,
  parameter int unsigned KEY_BITS   = tsc_pkg::DEF_KEY_BITS,
  parameter int unsigned TIME_BITS  = tsc_pkg::DEF_TIME_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsc_req_if.sink    req_i,
  tsc_rsp_if.source  rsp_o
);
  import tsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsc_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (req_i.operation),
    .tile_key_i     (req_i.tile_key),
    .tile_key_ok_i  (req_i.tile_key_ok),
    .now_time_i     (req_i.now_time),
    .max_free_i     (req_i.max_free),
    .slot_select_i  (req_i.slot_select),
    .stat_select_i  (req_i.stat_select),
    .slot_index_o   (rsp_o.slot_index),
    .slot_none_o    (rsp_o.slot_none),
    .was_resident_o (rsp_o.was_resident),
    .did_evict_o    (rsp_o.did_evict),
    .freed_count_o  (rsp_o.freed_count),
    .key_out_o      (rsp_o.key_out),
    .key_out_ok_o   (rsp_o.key_out_ok),
    .stat_value_o   (rsp_o.stat_value)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while a transaction is in progress");

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.upd_hit, cmd.ins_free, cmd.ins_evict, cmd.evict_one}))
    else $error("conflicting slot updates in one cycle");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> rsp_o.valid)
    else $error("result loaded without response valid");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_scan |=> (!req_i.ready && !status.scan_done))
    else $error("scan start did not hold the sequencer");

endmodule
